// ===== src/assert_macros.svh =====
// Assertion macros shared by the shared-pool stack block.
// Depends on nothing; every user has signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Overlapping implication: cons must hold in the same cycle as ante.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/spms_pkg.sv =====
// Shared constants, types and helper functions of the shared-pool stack block.
// Depends on nothing; imported by the link store and the top level.
package spms_pkg;

   localparam int NUM_STACKS = 8;
   localparam int POOL_SLOTS = 64;
   localparam int DATA_WIDTH = 32;

   localparam int OP_W       = 3;
   localparam int SIDX_W     = 3;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int RSP_DATA_W = 32;

   localparam int SLOT_W      = $clog2(POOL_SLOTS);
   localparam int LINK_W      = $clog2(POOL_SLOTS + 1);
   localparam int CNT_W       = $clog2(POOL_SLOTS + 1);
   localparam int STACK_IDX_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

   typedef logic [SLOT_W-1:0]             slot_type;
   typedef logic [LINK_W-1:0]             link_type;
   typedef logic [CNT_W-1:0]              count_type;
   typedef logic [STACK_IDX_W-1:0]        stack_idx_type;
   typedef logic signed [DATA_WIDTH-1:0]  word_type;

   // The null link is one past the last slot.
   localparam link_type NIL_LINK = LINK_W'(POOL_SLOTS);
   localparam word_type WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_MIN    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [SIDX_W-1:0]         stack_index;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]          status;
      logic signed [RSP_DATA_W-1:0] data;
   } rsp_type;

   typedef struct packed {
      logic     en;
      slot_type addr;
      link_type data;
   } link_wr_type;

   function automatic logic link_is_slot(link_type l);
      return l < NIL_LINK;
   endfunction

   function automatic slot_type to_slot(link_type l);
      return l[SLOT_W-1:0];
   endfunction

   // Link that a slot holds straight after reset: the following slot.
   function automatic link_type slot_next_link(slot_type s);
      return LINK_W'(s) + LINK_W'(1);
   endfunction

   function automatic logic signed [RSP_DATA_W-1:0] data_to_rsp(word_type v);
      return RSP_DATA_W'(v);
   endfunction

endpackage

// ===== src/shared_pool_multi_stack_core.sv =====
// Top level of the shared-pool multi-stack block: sequencer, stack heads,
// free list head and result register. Depends on spms_pkg, spms_ram,
// spms_link_store and assert_macros.svh.
//
// Usage. Requests arrive as beats on the req_ channel (valid and ready) and
// carry an operation, a stack index and a signed value. Every request gives
// exactly one result beat on the rsp_ channel: a status and a data word.
// Several stacks share one slot pool; each stack is a chain of slots linked
// from its top downward, and unused slots sit on a free chain.
// Timing. The block takes one request at a time and is not ready while it
// works on one. The shared link and value RAMs have a registered read, and
// the sequencer walks chains one slot per cycle through that read port.
// A request for an unknown op, an empty stack or a full pool goes from
// acceptance straight to the result state S_RESP; push first passes through
// S_PUSH_WR and pop through S_POP_WR. The block is ready again once the
// result has moved to the output register. Insert at bottom walks the stack
// to its last slot, delete middle walks it once to count its slots and then
// halfway again to the middle slot, and get minimum walks it once.
// Reset. A synchronous reset empties every stack, puts all slots on the free
// chain and drops any pending result; no clearing pass is needed.
// Stalls. A finished result waits in the output register until rsp_ready;
// the sequencer holds its last state until the output is free, and the next
// request may be taken while the previous result is still waiting.
module shared_pool_multi_stack_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  spms_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spms_pkg::rsp_type rsp_payload
);
   import spms_pkg::*;
   `include "assert_macros.svh"

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_PUSH_WR  = 4'd1;
   localparam logic [3:0] S_INS_WALK = 4'd2;
   localparam logic [3:0] S_INS_FIN  = 4'd3;
   localparam logic [3:0] S_POP_WR   = 4'd4;
   localparam logic [3:0] S_DM_COUNT = 4'd5;
   localparam logic [3:0] S_DM_SEEK  = 4'd6;
   localparam logic [3:0] S_DM_FREE  = 4'd7;
   localparam logic [3:0] S_MIN_WALK = 4'd8;
   localparam logic [3:0] S_RESP     = 4'd9;

   logic [3:0]      state_ff,  state_in;
   logic [OP_W-1:0] op_ff,     op_in;
   stack_idx_type   sidx_ff,   sidx_in;
   slot_type        n_ff,      n_in;       // newly taken slot
   link_type        p_ff,      p_in;       // head of the stack at acceptance
   slot_type        cur_ff,    cur_in;     // slot whose link is being read
   link_type        prev_ff,   prev_in;
   count_type       cnt_ff,    cnt_in;
   count_type       remain_ff, remain_in;
   word_type        best_ff,   best_in;
   rsp_type         result_ff, result_in;
   link_type        heads_ff [NUM_STACKS];
   link_type        heads_in [NUM_STACKS];
   link_type        free_head_ff, free_head_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_payload_ff, rsp_payload_in;

   slot_type        rd_addr;
   link_type        link_rd;
   link_wr_type     link_wr;
   logic            val_we;
   word_type        val_wdata;
   word_type        value_rd;
   word_type        min_next;
   stack_idx_type   req_sidx;
   link_type        req_head;

   spms_link_store u_links (
      .clock   (clock),
      .reset   (reset),
      .wr      (link_wr),
      .rd_addr (rd_addr),
      .rd_link (link_rd)
   );

   // Slot values share the read address of the link store, so a link and
   // the value of the same slot come back together.
   spms_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (POOL_SLOTS)
   ) u_values (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (to_slot(free_head_ff)),
      .wr_data (val_wdata),
      .rd_addr (rd_addr),
      .rd_data (value_rd)
   );

   assign req_sidx = STACK_IDX_W'(req_payload.stack_index);
   assign req_head = heads_ff[req_sidx];
   assign min_next = (value_rd < best_ff) ? value_rd : best_ff;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      sidx_in        = sidx_ff;
      n_in           = n_ff;
      p_in           = p_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      cnt_in         = cnt_ff;
      remain_in      = remain_ff;
      best_in        = best_ff;
      result_in      = result_ff;
      heads_in       = heads_ff;
      free_head_in   = free_head_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      rd_addr        = cur_ff;
      link_wr        = '0;
      val_we         = 1'b0;
      val_wdata      = DATA_WIDTH'(req_payload.value);
      req_ready      = (state_ff == S_IDLE);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_payload.op;
               sidx_in   = req_sidx;
               p_in      = req_head;
               n_in      = to_slot(free_head_ff);
               cur_in    = to_slot(req_head);
               cnt_in    = CNT_W'(1);
               best_in   = WORD_MAX;
               result_in = '{status: ST_OK, data: '0};
               state_in  = S_RESP;
               if (int'(req_payload.stack_index) >= NUM_STACKS) begin
                  // A stack that does not exist reads as empty, but an
                  // unknown op still reports ok.
                  if (req_payload.op <= OP_MIN) begin
                     result_in.status = ST_EMPTY;
                  end
               end else begin
                  unique case (req_payload.op) inside
                     OP_PUSH, OP_INSERT: begin
                        if (!link_is_slot(free_head_ff)) begin
                           result_in.status = ST_OVERFLOW;
                        end else begin
                           val_we   = 1'b1;
                           rd_addr  = to_slot(free_head_ff);
                           state_in = S_PUSH_WR;
                        end
                     end
                     OP_POP, OP_DELETE, OP_MIN: begin
                        if (!link_is_slot(req_head)) begin
                           result_in.status = ST_EMPTY;
                        end else begin
                           rd_addr = to_slot(req_head);
                           if (req_payload.op == OP_POP) begin
                              state_in = S_POP_WR;
                           end else if (req_payload.op == OP_DELETE) begin
                              state_in = S_DM_COUNT;
                           end else begin
                              state_in = S_MIN_WALK;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end

         S_PUSH_WR: begin
            // The free chain advances past the new slot before its link is
            // overwritten.
            free_head_in = link_rd;
            if (op_ff == OP_PUSH || !link_is_slot(p_ff)) begin
               link_wr           = '{en: 1'b1, addr: n_ff, data: p_ff};
               heads_in[sidx_ff] = LINK_W'(n_ff);
               state_in          = S_RESP;
            end else begin
               rd_addr  = to_slot(p_ff);
               cur_in   = to_slot(p_ff);
               state_in = S_INS_WALK;
            end
         end

         S_INS_WALK: begin
            if (link_is_slot(link_rd)) begin
               cur_in  = to_slot(link_rd);
               rd_addr = to_slot(link_rd);
            end else begin
               link_wr  = '{en: 1'b1, addr: cur_ff, data: LINK_W'(n_ff)};
               state_in = S_INS_FIN;
            end
         end

         S_INS_FIN: begin
            link_wr  = '{en: 1'b1, addr: n_ff, data: NIL_LINK};
            state_in = S_RESP;
         end

         S_POP_WR: begin
            heads_in[sidx_ff] = link_rd;
            link_wr           = '{en: 1'b1, addr: cur_ff, data: free_head_ff};
            free_head_in      = LINK_W'(cur_ff);
            result_in.data    = data_to_rsp(value_rd);
            state_in          = S_RESP;
         end

         S_DM_COUNT: begin
            if (link_is_slot(link_rd)) begin
               cnt_in  = cnt_ff + CNT_W'(1);
               rd_addr = to_slot(link_rd);
            end else begin
               remain_in = cnt_ff >> 1;
               cur_in    = to_slot(p_ff);
               prev_in   = NIL_LINK;
               rd_addr   = to_slot(p_ff);
               state_in  = S_DM_SEEK;
            end
         end

         S_DM_SEEK: begin
            if (remain_ff == '0) begin
               if (link_is_slot(prev_ff)) begin
                  link_wr = '{en: 1'b1, addr: to_slot(prev_ff), data: link_rd};
               end else begin
                  heads_in[sidx_ff] = link_rd;
               end
               result_in.data = data_to_rsp(value_rd);
               state_in       = S_DM_FREE;
            end else begin
               prev_in   = LINK_W'(cur_ff);
               cur_in    = to_slot(link_rd);
               remain_in = remain_ff - CNT_W'(1);
               rd_addr   = to_slot(link_rd);
            end
         end

         S_DM_FREE: begin
            link_wr      = '{en: 1'b1, addr: cur_ff, data: free_head_ff};
            free_head_in = LINK_W'(cur_ff);
            state_in     = S_RESP;
         end

         S_MIN_WALK: begin
            if (link_is_slot(link_rd)) begin
               best_in = min_next;
               rd_addr = to_slot(link_rd);
            end else begin
               result_in.data = data_to_rsp(min_next);
               state_in       = S_RESP;
            end
         end

         S_RESP: begin
            // The result moves to the output register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = result_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         free_head_ff <= '0;
         for (int i = 0; i < NUM_STACKS; i++) begin
            heads_ff[i] <= NIL_LINK;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         free_head_ff <= free_head_in;
         heads_ff     <= heads_in;
      end
      op_ff          <= op_in;
      sidx_ff        <= sidx_in;
      n_ff           <= n_in;
      p_ff           <= p_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      cnt_ff         <= cnt_in;
      remain_ff      <= remain_in;
      best_ff        <= best_in;
      result_ff      <= result_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
   `ASSERT_IMPLY(a_rsp_from_resp, $rose(rsp_valid_ff), $past(state_ff) == S_RESP, "stray result")
   `ASSERT_IMPLY(a_seek_in_chain, state_ff == S_DM_SEEK && remain_ff != '0, link_is_slot(link_rd), "seek ran off the chain")
   `ASSERT_IMPLY(a_overflow_full, state_ff == S_RESP && result_ff.status == ST_OVERFLOW, free_head_ff == NIL_LINK, "overflow with free slot")

endmodule

// ===== src/spms_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the slot values and the slot links.
module spms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/spms_link_store.sv =====
// Slot link store: a link RAM plus one valid bit per slot, so that an
// unwritten slot reads as its reset link. Depends on spms_pkg and spms_ram.
module spms_link_store (
   input  logic                 clock,
   input  logic                 reset,
   input  spms_pkg::link_wr_type wr,
   input  spms_pkg::slot_type   rd_addr,
   output spms_pkg::link_type   rd_link
);
   import spms_pkg::*;

   logic [POOL_SLOTS-1:0] valid_ff;
   logic [POOL_SLOTS-1:0] valid_in;
   logic                  rd_valid_ff;
   slot_type              rd_addr_ff;
   link_type              ram_rd;

   spms_ram #(
      .WIDTH (LINK_W),
      .DEPTH (POOL_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      rd_valid_ff <= valid_ff[rd_addr];
      rd_addr_ff  <= rd_addr;
   end

   // A slot never written still holds its reset link to the following slot.
   assign rd_link = rd_valid_ff ? ram_rd : slot_next_link(rd_addr_ff);

endmodule
